FILE: hdl/assert_macros.svh
// assertion macros shared by the rasterizer rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/trast_pkg.sv
// shared types, constants and helpers of the triangle rasterizer
// used by trast_ctrl, trast_dp and triangle_rasterizer_unit
`default_nettype none

package trast_pkg;

	localparam int DEF_FRAME_WIDTH   = 8;
	localparam int DEF_FRAME_HEIGHT  = 8;
	localparam int DEF_SUBPIXEL_BITS = 4;

	localparam int MAX_FRAGS = 64;
	localparam int CNT_W     = 7;
	localparam int IN_W      = 112;
	localparam int OUT_W     = 88;
	localparam int NATTR     = 7;

	localparam int DW     = 22; // multiplier operand width
	localparam int PW     = 44; // product width
	localparam int EW     = 40; // edge value width
	localparam int AW     = 58; // accumulator width
	localparam int RW     = 60; // divider width
	localparam int QB     = 18; // quotient bits
	localparam int ESPLIT = 20; // edge value split for attribute products

	localparam logic [2:0] AOP_NONE  = 3'd0;
	localparam logic [2:0] AOP_LOAD  = 3'd1;
	localparam logic [2:0] AOP_ADD   = 3'd2;
	localparam logic [2:0] AOP_ADDSH = 3'd3;
	localparam logic [2:0] AOP_SUB   = 3'd4;

	localparam logic [1:0] EK_AREA = 2'd3;

	localparam logic [2:0] ATTR_DEPTH = 3'd0;
	localparam logic [2:0] ATTR_U     = 3'd1;
	localparam logic [2:0] ATTR_V     = 3'd2;
	localparam logic [2:0] ATTR_ALPHA = 3'd6;

	typedef struct packed {
		logic       vtx_wr;
		logic [1:0] vtx_idx;
		logic       mul_attr;
		logic [1:0] edge_k;
		logic       half;
		logic [1:0] vsel;
		logic       ehi;
		logic [2:0] aidx;
		logic [2:0] aop;
		logic       area_latch;
		logic       e_latch;
		logic [1:0] e_idx;
		logic       scan_init;
		logic       pix_next;
		logic       div_init;
		logic       div_step;
		logic       attr_store;
		logic       push;
		logic       fin_push;
	} trast_cmd_t;

	typedef struct packed {
		logic area_zero;
		logic box_off;
		logic covered;
		logic x_end;
		logic y_end;
		logic out_free;
		logic pend_valid;
		logic cnt_full;
	} trast_sts_t;

	function automatic logic [15:0] attr_sat(input logic [2:0] idx,
		input logic signed [QB:0] r);
		logic [15:0] res;
		if (idx == ATTR_DEPTH) begin
			if (r < 0)
				res = 16'd0;
			else if (r > 19'sd65535)
				res = 16'hFFFF;
			else
				res = r[15:0];
		end else if (idx == ATTR_U || idx == ATTR_V) begin
			if (r < -19'sd32768)
				res = 16'h8000;
			else if (r > 19'sd32767)
				res = 16'h7FFF;
			else
				res = r[15:0];
		end else begin
			if (r < 0)
				res = 16'd0;
			else if (r > 19'sd255)
				res = 16'd255;
			else
				res = {8'd0, r[7:0]};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/triangle_rasterizer_unit.sv
// top level of the edge-function triangle rasterizer
// depends on trast_pkg, trast_ctrl and trast_dp
//
//  channel   dir  signals                       content
//  vertex    in   s_tvalid s_tready s_tdata     one vertex per beat
//  fragment  out  m_tvalid m_tready m_tdata     one covered pixel per beat, m_tlast on final
//
// first and second vertex: stored
// third vertex: setup (area through the shared multiplier), then for each box pixel
//   the edge values, plus for each covered pixel its attributes, each by
//   multiply-accumulate steps and restoring divide steps, and an emit step
// these steps run on the divider and the single multiplier; no vertex is taken until
//   the last fragment is in the output register
// a full output register stalls the scan at the emit step
// arst_n clears the sequencer, the vertex count and the output valid
`default_nettype none

module triangle_rasterizer_unit
	import trast_pkg::*;
#(
	parameter int FRAME_WIDTH   = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT  = DEF_FRAME_HEIGHT,
	parameter int SUBPIXEL_BITS = DEF_SUBPIXEL_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// pos_x, pos_y, vert_depth, tex_u, tex_v, red_in, green_in, blue_in, alpha_in
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// pixel_x, pixel_y, frag_depth, frag_u, frag_v, frag_red, frag_green,
	// frag_blue, frag_alpha, two zero bits
	output logic [OUT_W-1:0]      m_tdata,
	// last_fragment
	output logic                  m_tlast
);

	trast_cmd_t cmd;
	trast_sts_t sts;

	trast_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	trast_dp #(
		.FRAME_WIDTH   (FRAME_WIDTH),
		.FRAME_HEIGHT  (FRAME_HEIGHT),
		.SUBPIXEL_BITS (SUBPIXEL_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

FILE: hdl/trast_ctrl.sv
// sequencer of the rasterizer: vertex intake, setup, pixel scan, attribute divides
// depends on trast_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module trast_ctrl
	import trast_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  trast_sts_t      sts,
	output trast_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_PIX   = 3'd2;
	localparam logic [2:0] ST_ATTR  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [4:0] st_q, st_d;
	logic [2:0] ai_q, ai_d;
	logic [1:0] vcnt_q, vcnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q    <= '0;
			ai_q    <= '0;
			vcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			ai_q    <= ai_d;
			vcnt_q  <= vcnt_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.aop = AOP_NONE;
		state_d = state_q;
		st_d    = st_q;
		ai_d    = ai_q;
		vcnt_d  = vcnt_q;
		s_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.vtx_wr  = 1'b1;
					cmd.vtx_idx = vcnt_q;
					if (vcnt_q == 2'd2) begin
						vcnt_d  = 2'd0;
						state_d = ST_SETUP;
						st_d    = '0;
					end else begin
						vcnt_d = vcnt_q + 2'd1;
					end
				end
			end
			ST_SETUP: begin
				cmd.edge_k = EK_AREA;
				cmd.half   = st_q[0];
				st_d       = st_q + 5'd1;
				if (st_q == 5'd0)
					cmd.aop = AOP_LOAD;
				if (st_q == 5'd1)
					cmd.aop = AOP_SUB;
				if (st_q == 5'd3)
					cmd.area_latch = 1'b1;
				if (st_q == 5'd4) begin
					st_d = '0;
					if (sts.area_zero || sts.box_off) begin
						state_d = ST_IDLE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d = ST_PIX;
					end
				end
			end
			ST_PIX: begin
				// for each edge, one product is loaded and another subtracted; the product is registered before it is accumulated
				cmd.edge_k = st_q[2:1];
				cmd.half   = st_q[0];
				st_d       = st_q + 5'd1;
				if (st_q < 5'd6)
					cmd.aop = st_q[0] ? AOP_SUB : AOP_LOAD;
				if (st_q == 5'd3 || st_q == 5'd5 || st_q == 5'd7) begin
					cmd.e_latch = 1'b1;
					cmd.e_idx   = st_q[2:1] - 2'd1;
				end
				if (st_q == 5'd8) begin
					st_d = '0;
					if (sts.covered) begin
						ai_d    = '0;
						state_d = ST_ATTR;
					end else if (sts.x_end && sts.y_end) begin
						state_d = ST_FIN;
					end else begin
						cmd.pix_next = 1'b1;
					end
				end
			end
			ST_ATTR: begin
				cmd.mul_attr = 1'b1;
				cmd.aidx     = ai_q;
				cmd.vsel     = st_q[2:1];
				cmd.ehi      = st_q[0];
				st_d         = st_q + 5'd1;
				if (st_q < 5'd6) begin
					if (st_q == 5'd0)
						cmd.aop = AOP_LOAD;
					else
						cmd.aop = st_q[0] ? AOP_ADDSH : AOP_ADD;
				end
				if (st_q == 5'd7)
					cmd.div_init = 1'b1;
				if (st_q >= 5'd8 && st_q < 5'd26)
					cmd.div_step = 1'b1;
				if (st_q == 5'd26) begin
					cmd.attr_store = 1'b1;
					st_d = '0;
					if (ai_q == ATTR_ALPHA)
						state_d = ST_EMIT;
					else
						ai_d = ai_q + 3'd1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					st_d = '0;
					if (sts.cnt_full || (sts.x_end && sts.y_end)) begin
						state_d = ST_FIN;
					end else begin
						cmd.pix_next = 1'b1;
						state_d = ST_PIX;
					end
				end
			end
			ST_FIN: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.fin_push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_fin_to_idle, clk, arst_n, cmd.fin_push, state_q == ST_IDLE)
	`ASSERT_IMPLIES(a_vcnt_range, clk, arst_n, 1'b1, vcnt_q != 2'd3)
	`ASSERT_IMPLIES(a_wr_only_idle, clk, arst_n, cmd.vtx_wr, s_tready && s_tvalid)

endmodule

`default_nettype wire

FILE: hdl/trast_dp.sv
// rasterizer datapath: vertex store, shared multiplier and accumulator,
// box setup, scan counters, restoring divider, pending fragment and output beat
// depends on trast_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module trast_dp
	import trast_pkg::*;
#(
	parameter int FRAME_WIDTH   = DEF_FRAME_WIDTH,
	parameter int FRAME_HEIGHT  = DEF_FRAME_HEIGHT,
	parameter int SUBPIXEL_BITS = DEF_SUBPIXEL_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  trast_cmd_t            cmd,
	output trast_sts_t            sts,
	input  wire logic             m_tready,
	output logic                  m_tvalid,
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  m_tlast
);

	localparam int XW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
	localparam int YW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

	// vertex store
	logic signed [15:0] x0_q, x1_q, x2_q, y0_q, y1_q, y2_q;
	logic [NATTR-1:0][15:0] at0_q, at1_q, at2_q;
	logic [NATTR-1:0][15:0] in_attr;

	assign in_attr = {{8'd0, s_tdata[111:104]}, {8'd0, s_tdata[103:96]},
		{8'd0, s_tdata[95:88]}, {8'd0, s_tdata[87:80]},
		s_tdata[79:64], s_tdata[63:48], s_tdata[47:32]};

	always_ff @(posedge clk) begin
		if (cmd.vtx_wr) begin
			unique case (cmd.vtx_idx)
				2'd0: begin
					x0_q <= s_tdata[15:0]; y0_q <= s_tdata[31:16]; at0_q <= in_attr;
				end
				2'd1: begin
					x1_q <= s_tdata[15:0]; y1_q <= s_tdata[31:16]; at1_q <= in_attr;
				end
				default: begin
					x2_q <= s_tdata[15:0]; y2_q <= s_tdata[31:16]; at2_q <= in_attr;
				end
			endcase
		end
	end

	// doubled coordinates
	logic signed [DW-1:0] dx0, dx1, dx2, dy0, dy1, dy2, cx, cy;
	logic [XW-1:0] x_q, xs_q, xe_q;
	logic [YW-1:0] y_q, ys_q, ye_q;

	assign dx0 = {{(DW-17){x0_q[15]}}, x0_q, 1'b0};
	assign dx1 = {{(DW-17){x1_q[15]}}, x1_q, 1'b0};
	assign dx2 = {{(DW-17){x2_q[15]}}, x2_q, 1'b0};
	assign dy0 = {{(DW-17){y0_q[15]}}, y0_q, 1'b0};
	assign dy1 = {{(DW-17){y1_q[15]}}, y1_q, 1'b0};
	assign dy2 = {{(DW-17){y2_q[15]}}, y2_q, 1'b0};
	// pixel center in doubled subpixel units
	assign cx = (DW'(x_q) << (SUBPIXEL_BITS + 1)) | (DW'(1) << SUBPIXEL_BITS);
	assign cy = (DW'(y_q) << (SUBPIXEL_BITS + 1)) | (DW'(1) << SUBPIXEL_BITS);

	// multiplier operand selection
	logic signed [DW-1:0] ax, ay, bx, by, ppx, ppy, opa, opb;
	logic signed [EW-1:0] e0_q, e1_q, e2_q, esel;
	logic [15:0] araw;
	logic signed [DW-1:0] aval;

	always_comb begin
		unique case (cmd.edge_k)
			2'd0: begin ax = dx1; ay = dy1; bx = dx2; by = dy2; end
			2'd1: begin ax = dx2; ay = dy2; bx = dx0; by = dy0; end
			2'd2: begin ax = dx0; ay = dy0; bx = dx1; by = dy1; end
			default: begin ax = dx1; ay = dy1; bx = dx2; by = dy2; end
		endcase
		if (cmd.edge_k == EK_AREA) begin
			ppx = dx0;
			ppy = dy0;
		end else begin
			ppx = cx;
			ppy = cy;
		end
		unique case (cmd.vsel)
			2'd0: begin esel = e0_q; araw = at0_q[cmd.aidx]; end
			2'd1: begin esel = e1_q; araw = at1_q[cmd.aidx]; end
			default: begin esel = e2_q; araw = at2_q[cmd.aidx]; end
		endcase
		if (cmd.aidx == ATTR_U || cmd.aidx == ATTR_V)
			aval = {{(DW-16){araw[15]}}, araw};
		else
			aval = {{(DW-16){1'b0}}, araw};
		if (cmd.mul_attr) begin
			opa = aval;
			opb = cmd.ehi ? {{(DW-(EW-ESPLIT)){1'b0}}, esel[EW-1:ESPLIT]}
				: {{(DW-ESPLIT){1'b0}}, esel[ESPLIT-1:0]};
		end else if (cmd.half) begin
			opa = ppy - by;
			opb = ax - bx;
		end else begin
			opa = ppx - bx;
			opb = ay - by;
		end
	end

	logic signed [PW-1:0] prod_c, prod_q;
	logic signed [AW-1:0] acc_q, pext;
	logic [2:0] aop_q;

	assign prod_c = opa * opb;
	assign pext   = AW'(prod_q);

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		unique case (aop_q)
			AOP_LOAD:  acc_q <= pext;
			AOP_ADD:   acc_q <= acc_q + pext;
			AOP_ADDSH: acc_q <= acc_q + (pext <<< ESPLIT);
			AOP_SUB:   acc_q <= acc_q - pext;
			default:   acc_q <= acc_q;
		endcase
	end

	// area, orientation and clipped box
	logic signed [EW-1:0] edge_v;
	logic [EW-1:0] area_q;
	logic sgn_neg_q, area_zero_q, box_off_q;
	logic signed [15:0] mnx, mxx, mny, mxy;
	logic [15:0] xs_w, xe_w, ys_w, ye_w, xe_cl, ye_cl;
	logic off_w;

	assign edge_v = acc_q[EW-1:0];

	function automatic logic signed [15:0] min3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [15:0] max3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	always_comb begin
		mnx = min3(x0_q, x1_q, x2_q);
		mxx = max3(x0_q, x1_q, x2_q);
		mny = min3(y0_q, y1_q, y2_q);
		mxy = max3(y0_q, y1_q, y2_q);
		xs_w = (mnx[15] ? 16'd0 : mnx) >> SUBPIXEL_BITS;
		ys_w = (mny[15] ? 16'd0 : mny) >> SUBPIXEL_BITS;
		xe_w = 16'(mxx) >> SUBPIXEL_BITS;
		ye_w = 16'(mxy) >> SUBPIXEL_BITS;
		xe_cl = (xe_w > 16'(FRAME_WIDTH - 1)) ? 16'(FRAME_WIDTH - 1) : xe_w;
		ye_cl = (ye_w > 16'(FRAME_HEIGHT - 1)) ? 16'(FRAME_HEIGHT - 1) : ye_w;
		// box wholly off the frame, or clipped to nothing
		off_w = mxx[15] || mxy[15] || (xs_w > xe_cl) || (ys_w > ye_cl);
	end

	always_ff @(posedge clk) begin
		if (cmd.area_latch) begin
			sgn_neg_q   <= edge_v[EW-1];
			area_q      <= edge_v[EW-1] ? EW'(-edge_v) : EW'(edge_v);
			area_zero_q <= (edge_v == '0);
			box_off_q   <= off_w;
			xs_q <= xs_w[XW-1:0];
			xe_q <= xe_cl[XW-1:0];
			ys_q <= ys_w[YW-1:0];
			ye_q <= ye_cl[YW-1:0];
		end
		if (cmd.e_latch) begin
			unique case (cmd.e_idx)
				2'd0: e0_q <= sgn_neg_q ? -edge_v : edge_v;
				2'd1: e1_q <= sgn_neg_q ? -edge_v : edge_v;
				default: e2_q <= sgn_neg_q ? -edge_v : edge_v;
			endcase
		end
		if (cmd.scan_init) begin
			x_q <= xs_q;
			y_q <= ys_q;
		end else if (cmd.pix_next) begin
			if (x_q == xe_q) begin
				x_q <= xs_q;
				y_q <= y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// restoring divider on magnitudes, floor toward minus infinity on sign
	logic signed [RW-1:0] nval;
	logic [RW-1:0] rem_q, ds_q;
	logic [QB-1:0] q_q;
	logic neg_q;
	logic signed [QB:0] qext, qres;

	assign nval = (RW'(acc_q) <<< 1) + $signed({{(RW-EW){1'b0}}, area_q});
	assign qext = $signed({1'b0, q_q});
	assign qres = neg_q ? (-qext - $signed({{QB{1'b0}}, (rem_q != '0)})) : qext;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= nval[RW-1];
			rem_q <= nval[RW-1] ? RW'(-nval) : RW'(nval);
			ds_q  <= {{(RW-EW){1'b0}}, area_q} << QB;
			q_q   <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= ds_q) begin
				rem_q <= rem_q - ds_q;
				q_q   <= {q_q[QB-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[QB-2:0], 1'b0};
			end
			ds_q <= ds_q >> 1;
		end
	end

	// fragment under construction, pending fragment and output beat
	logic [NATTR-1:0][15:0] fr_q, pend_at_q;
	logic [2:0] pend_x_q, pend_y_q;
	logic [15:0] xw, yw;
	logic pend_valid_q, out_valid_q, out_last_q;
	logic [OUT_W-1:0] out_data_q;
	logic [CNT_W-1:0] n_q;
	logic out_free, out_load;

	assign xw = 16'(x_q);
	assign yw = 16'(y_q);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (cmd.push && pend_valid_q) || cmd.fin_push;

	always_ff @(posedge clk) begin
		if (cmd.attr_store)
			fr_q[cmd.aidx] <= attr_sat(cmd.aidx, qres);
		if (cmd.push) begin
			pend_at_q <= fr_q;
			pend_x_q  <= xw[2:0];
			pend_y_q  <= yw[2:0];
		end
		if (out_load) begin
			out_data_q <= {2'b00, pend_at_q[6][7:0], pend_at_q[5][7:0], pend_at_q[4][7:0],
				pend_at_q[3][7:0], pend_at_q[2], pend_at_q[1], pend_at_q[0],
				pend_y_q, pend_x_q};
			out_last_q <= cmd.fin_push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aop_q        <= AOP_NONE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
		end else begin
			aop_q <= cmd.aop;
			if (cmd.scan_init)
				n_q <= '0;
			else if (cmd.push)
				n_q <= n_q + CNT_W'(1);
			if (cmd.push)
				pend_valid_q <= 1'b1;
			else if (cmd.fin_push || cmd.scan_init)
				pend_valid_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		sts.area_zero  = area_zero_q;
		sts.box_off    = box_off_q;
		sts.covered    = !e0_q[EW-1] && !e1_q[EW-1] && !e2_q[EW-1];
		sts.x_end      = (x_q == xe_q);
		sts.y_end      = (y_q == ye_q);
		sts.out_free   = out_free;
		sts.pend_valid = pend_valid_q;
		sts.cnt_full   = (n_q == CNT_W'(MAX_FRAGS - 1));
	end

	`ASSERT_IMPLIES(a_load_needs_room, clk, arst_n, out_load, out_free)
	`ASSERT_IMPLIES(a_fin_has_pending, clk, arst_n, cmd.fin_push, pend_valid_q)
	`ASSERT_IMPLIES(a_frag_cap, clk, arst_n, 1'b1, n_q <= CNT_W'(MAX_FRAGS))

endmodule

`default_nettype wire
